[design/fence_tagged_release_queue_top_macros.svh]
// Assertion macros for the release queue checker.
// Both expect clk and rst_n in scope and stay quiet while reset is asserted.
`ifndef FENCE_TAGGED_RELEASE_QUEUE_TOP_MACROS_SVH
`define FENCE_TAGGED_RELEASE_QUEUE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define FTRQ_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FTRQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ftrq_pkg.sv]
package ftrq_pkg;

    // Field widths
    localparam int DEFAULT_DEPTH = 32;
    localparam int CMD_W         = 3;
    localparam int HANDLE_W      = 32;
    localparam int FENCE_W       = 64;
    localparam int COUNT_W       = 6;
    localparam int STATUS_W      = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FENCE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_UNSEALED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEAL          = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COLLECT       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE_ALL   = 3'd4;

    // Summary status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // Command transaction
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] handle;
        logic                handle_valid;
        logic                is_descriptor;
        logic [FENCE_W-1:0]  fence;
    } ftrq_in_t;

    // Result transaction
    typedef struct packed {
        logic [HANDLE_W-1:0] released_handle;
        logic                released_kind;
        logic                is_release;
        logic [COUNT_W-1:0]  released_count;
        logic [COUNT_W-1:0]  pending_count;
        logic [STATUS_W-1:0] status;
        logic                last;
    } ftrq_out_t;

    // One table entry
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                kind;
        logic [FENCE_W-1:0]  fence;
        logic                sealed;
    } ftrq_slot_t;

    // Per-slot decision from the compare unit
    typedef struct packed {
        logic rel;      // emit this entry
        logic seal_wr;  // rewrite entry with the seal fence
        logic keep;     // entry survives a collect
    } ftrq_act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUMMARY
    } ftrq_state_t;

endpackage

[design/ftrq_slot_mem.sv]
module ftrq_slot_mem #(
    parameter int DEPTH = ftrq_pkg::DEFAULT_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  ftrq_pkg::ftrq_slot_t     wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output ftrq_pkg::ftrq_slot_t     rd_data
);
    import ftrq_pkg::*;

    ftrq_slot_t slot_mem [DEPTH];
    ftrq_slot_t rd_data_reg;

    // Single write port, single registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ftrq_cmp_unit.sv]
module ftrq_cmp_unit (
    input  logic [ftrq_pkg::CMD_W-1:0]   cmd,
    input  ftrq_pkg::ftrq_slot_t         slot,
    input  logic [ftrq_pkg::FENCE_W-1:0] cmp_fence,
    output ftrq_pkg::ftrq_act_t          act
);
    import ftrq_pkg::*;

    logic done;

    // Shared 64-bit fence compare: entry complete once sealed and fence passed
    assign done = slot.sealed && (slot.fence <= cmp_fence);

    // Decide what the sequencer does with the slot under the scan pointer
    always_comb
    begin
        act = '0;
        case (cmd)
            CMD_SEAL:
            begin
                act.seal_wr = !slot.sealed;
            end
            CMD_COLLECT:
            begin
                act.rel  = done;
                act.keep = !done;
            end
            CMD_RELEASE_ALL:
            begin
                act.rel = 1'b1;
            end
            default:
            begin
                act = '0;
            end
        endcase
    end

endmodule

[design/ftrq_seq.sv]
module ftrq_seq #(
    parameter int DEPTH = ftrq_pkg::DEFAULT_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  ftrq_pkg::ftrq_in_t           cmd_data,
    output logic                         res_valid,
    input  logic                         res_stall,
    output ftrq_pkg::ftrq_out_t          res_data,
    output logic                         mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]     mem_wr_addr,
    output ftrq_pkg::ftrq_slot_t         mem_wr_data,
    output logic                         mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]     mem_rd_addr,
    input  ftrq_pkg::ftrq_slot_t         mem_rd_data,
    output logic [ftrq_pkg::CMD_W-1:0]   op_cmd,
    output logic [ftrq_pkg::FENCE_W-1:0] op_fence,
    input  ftrq_pkg::ftrq_act_t          act
);
    import ftrq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    ftrq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     kept_reg, kept_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]     rel_reg, rel_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [FENCE_W-1:0]   fence_reg, fence_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;
    ftrq_out_t            out_data_reg, out_data_next;

    logic             accept;
    logic             out_free;
    logic             is_push;
    logic             is_scan;
    logic             scan_go;
    logic             last_slot;
    logic [CNT_W-1:0] fin_occ;
    logic [IDX_W-1:0] idx_inc;

    // Handshake and decode
    assign accept    = (state_reg == ST_IDLE) && cmd_valid;
    assign out_free  = !out_valid_reg || !res_stall;
    assign is_push   = (cmd_data.cmd == CMD_PUSH_FENCE) || (cmd_data.cmd == CMD_PUSH_UNSEALED);
    assign is_scan   = (cmd_data.cmd == CMD_SEAL) || (cmd_data.cmd == CMD_COLLECT)
                    || (cmd_data.cmd == CMD_RELEASE_ALL);
    assign scan_go   = !act.rel || out_free;
    assign last_slot = (CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg;
    assign idx_inc   = idx_reg + IDX_W'(1);

    // Occupancy once the current command completes
    always_comb
    begin
        case (cmd_reg)
            CMD_COLLECT:     fin_occ = kept_reg;
            CMD_RELEASE_ALL: fin_occ = '0;
            default:         fin_occ = occ_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_scan && (occ_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SUMMARY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_go && last_slot)
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and result register
    always_comb
    begin
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        occ_next       = occ_reg;
        rel_next       = rel_reg;
        cmd_next       = cmd_reg;
        fence_next     = fence_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd_data.cmd;
                    fence_next  = cmd_data.fence;
                    rel_next    = '0;
                    kept_next   = '0;
                    idx_next    = '0;
                    status_next = STATUS_OK;
                    if (is_push)
                    begin
                        if (!cmd_data.handle_valid)
                        begin
                            status_next = STATUS_INVALID;
                        end
                        else if (occ_reg == DEPTH_CNT)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // append at the tail
                            mem_wr_en          = 1'b1;
                            mem_wr_addr        = occ_reg[IDX_W-1:0];
                            mem_wr_data.handle = cmd_data.handle;
                            mem_wr_data.kind   = cmd_data.is_descriptor;
                            mem_wr_data.fence  = cmd_data.fence;
                            mem_wr_data.sealed = (cmd_data.cmd == CMD_PUSH_FENCE);
                            occ_next           = occ_reg + CNT_W'(1);
                        end
                    end
                    if (is_scan && (occ_reg != '0))
                    begin
                        // prefetch the head slot
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    if (act.rel)
                    begin
                        out_valid_next                = 1'b1;
                        out_data_next                 = '0;
                        out_data_next.released_handle = mem_rd_data.handle;
                        out_data_next.released_kind   = mem_rd_data.kind;
                        out_data_next.is_release      = 1'b1;
                        rel_next                      = rel_reg + CNT_W'(1);
                    end
                    if (act.seal_wr)
                    begin
                        mem_wr_en          = 1'b1;
                        mem_wr_addr        = idx_reg;
                        mem_wr_data.fence  = fence_reg;
                        mem_wr_data.sealed = 1'b1;
                    end
                    if (act.keep)
                    begin
                        // stable compaction: survivor moves down to the kept count
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = kept_reg[IDX_W-1:0];
                        kept_next   = kept_reg + CNT_W'(1);
                    end
                    if (!last_slot)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_inc;
                        idx_next    = idx_inc;
                    end
                end
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next                = '0;
                    out_data_next.released_count = COUNT_W'(rel_reg);
                    out_data_next.pending_count  = COUNT_W'(fin_occ);
                    out_data_next.status         = status_reg;
                    out_data_next.last           = 1'b1;
                    occ_next                     = fin_occ;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && res_stall;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        kept_reg     <= kept_next;
        rel_reg      <= rel_next;
        cmd_reg      <= cmd_next;
        fence_reg    <= fence_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;
    assign op_cmd    = cmd_reg;
    assign op_fence  = fence_reg;

endmodule

[design/fence_tagged_release_queue_top.sv]
// Fence-tagged deferred release queue.
// Command channel (cmd_valid / cmd_stall / cmd_data): push with fence, push
// unsealed, seal, collect, release all. Result channel (res_valid / res_stall /
// res_data): one release transaction per freed entry, in queue order, then one
// summary transaction with last set, the released and pending counts and status.
// Flow: a command is taken only when the block is idle. A push goes straight
// to the summary state, which loads its summary into the output register.
// Seal, collect and release all walk the occupied slots one per cycle, while
// no release is held back, through the slot memory's single read port and the
// shared fence comparator. Empty-table scans and unknown codes go straight to
// the summary state.
// A result waits in the output register while res_stall is high; the slot walk
// pauses on any entry that must be emitted until the register frees.
// Reset empties the table and drops any pending result; slot contents are not
// cleared and need no clearing pass.
module fence_tagged_release_queue_top #(
    parameter int QUEUE_DEPTH = ftrq_pkg::DEFAULT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ftrq_pkg::ftrq_in_t  cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output ftrq_pkg::ftrq_out_t res_data
);
    import ftrq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    ftrq_slot_t         mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    ftrq_slot_t         mem_rd_data;
    logic [CMD_W-1:0]   op_cmd;
    logic [FENCE_W-1:0] op_fence;
    ftrq_act_t          act;

    // Sequencer: command decode, slot walk and result register
    ftrq_seq #(
        .DEPTH(QUEUE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .mem_wr_en  (mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data),
        .mem_rd_en  (mem_rd_en),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .op_cmd     (op_cmd),
        .op_fence   (op_fence),
        .act        (act)
    );

    // Slot table
    ftrq_slot_mem #(
        .DEPTH(QUEUE_DEPTH)
    ) u_slot_mem (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    // Shared fence comparator
    ftrq_cmp_unit u_cmp_unit (
        .cmd      (op_cmd),
        .slot     (mem_rd_data),
        .cmp_fence(op_fence),
        .act      (act)
    );

endmodule

[design/ftrq_checker.sv]
`include "fence_tagged_release_queue_top_macros.svh"

module ftrq_checker #(
    parameter int DEPTH = ftrq_pkg::DEFAULT_DEPTH
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input ftrq_pkg::ftrq_in_t  cmd_data,
    input logic                res_valid,
    input logic                res_stall,
    input ftrq_pkg::ftrq_out_t res_data
);
    import ftrq_pkg::*;

    logic res_held;
    logic cmd_held;
    logic cmd_taken;
    logic rel_shown;
    logic sum_shown;
    logic pend_ok;

    // Handshake views used by the properties below
    assign res_held  = res_valid && res_stall;
    assign cmd_held  = cmd_valid && cmd_stall;
    assign cmd_taken = cmd_valid && !cmd_stall;
    assign rel_shown = res_valid && res_data.is_release;
    assign sum_shown = res_valid && res_data.last;
    assign pend_ok   = (res_data.pending_count <= COUNT_W'(DEPTH)) && !res_data.is_release;

    // A held result transaction keeps its payload
    `FTRQ_ASSERT_NEXT(a_res_hold, res_held, res_valid && $stable(res_data), "result moved")

    // A stalled command transaction keeps its payload
    `FTRQ_ASSERT_NEXT(a_cmd_hold, cmd_held, cmd_valid && $stable(cmd_data), "command moved")

    // Every accepted command keeps the block busy in the cycle after acceptance
    `FTRQ_ASSERT_NEXT(a_busy_after_cmd, cmd_taken, cmd_stall, "no busy cycle")

    // A release transaction is always followed by its summary, so the block stays busy
    `FTRQ_ASSERT_SAME(a_rel_busy, rel_shown, cmd_stall && !res_data.last, "release while idle")

    // Summary never reports more pending entries than the table holds
    `FTRQ_ASSERT_SAME(a_pending_bound, sum_shown, pend_ok, "pending count beyond depth")

endmodule

bind fence_tagged_release_queue_top ftrq_checker #(
    .DEPTH(QUEUE_DEPTH)
) u_ftrq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data (cmd_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
);

[tb/tb_fence_tagged_release_queue_top.sv]
`timescale 1ns / 100ps

module tb_fence_tagged_release_queue_top;

    import ftrq_pkg::*;

    localparam int QUEUE_DEPTH    = DEFAULT_DEPTH;
    localparam int ITEM_TARGET    = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 4;

    // Command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    localparam logic [FENCE_W-1:0] FENCE_MAX = '1;

    // Directed row: command plus an optional hand-written summary
    typedef struct packed {
        ftrq_in_t  cmd;
        logic      typed;
        ftrq_out_t summary;
    } cmd_row_t;

    typedef struct packed {
        logic      typed;
        ftrq_out_t summary;
    } summary_hint_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    ftrq_in_t  cmd_data;
    logic      res_valid;
    logic      res_stall;
    ftrq_out_t res_data;

    // Shadow copy of the release table
    ftrq_slot_t shadow_slots [QUEUE_DEPTH];
    int         shadow_occ;

    ftrq_out_t     owed_results [$];
    summary_hint_t summary_hints [$];
    cmd_row_t      directed_rows [$];

    int  fault_count;
    int  idle_cycles;
    int  items_sent;
    int  accepted_cmds;
    int  release_results;
    int  summary_results;
    int  full_hits;
    int  invalid_hits;
    int  peak_occ;
    bit  calm;
    bit  stall_quiet;

    fence_tagged_release_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Failure bookkeeping: only the first ten are printed
    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic ftrq_out_t release_of(input ftrq_slot_t s);
        ftrq_out_t r;
        r = '0;
        r.released_handle = s.handle;
        r.released_kind   = s.kind;
        r.is_release      = 1'b1;
        return r;
    endfunction

    // Apply one command to the shadow table; releases are queued here,
    // the closing summary is handed back to the caller
    task automatic model_step(input ftrq_in_t c, output ftrq_out_t summary);
        int                  kept;
        int                  freed;
        logic [STATUS_W-1:0] st;
        kept  = 0;
        freed = 0;
        st    = STATUS_OK;
        case (c.cmd)
            CMD_PUSH_FENCE, CMD_PUSH_UNSEALED:
            begin
                if (!c.handle_valid)
                    st = STATUS_INVALID;
                else if (shadow_occ >= QUEUE_DEPTH)
                    st = STATUS_FULL;
                else
                begin
                    shadow_slots[shadow_occ].handle = c.handle;
                    shadow_slots[shadow_occ].kind   = c.is_descriptor;
                    shadow_slots[shadow_occ].fence  = c.fence;
                    shadow_slots[shadow_occ].sealed = (c.cmd == CMD_PUSH_FENCE);
                    shadow_occ++;
                end
            end
            CMD_SEAL:
            begin
                for (int i = 0; i < shadow_occ; i++)
                begin
                    if (!shadow_slots[i].sealed)
                    begin
                        shadow_slots[i].fence  = c.fence;
                        shadow_slots[i].sealed = 1'b1;
                    end
                end
            end
            CMD_COLLECT:
            begin
                // stable compaction of the survivors
                for (int i = 0; i < shadow_occ; i++)
                begin
                    if (shadow_slots[i].sealed && shadow_slots[i].fence <= c.fence)
                    begin
                        owed_results.insert(owed_results.size(), release_of(shadow_slots[i]));
                        freed++;
                    end
                    else
                    begin
                        shadow_slots[kept] = shadow_slots[i];
                        kept++;
                    end
                end
                shadow_occ = kept;
            end
            CMD_RELEASE_ALL:
            begin
                for (int i = 0; i < shadow_occ; i++)
                begin
                    owed_results.insert(owed_results.size(), release_of(shadow_slots[i]));
                    freed++;
                end
                shadow_occ = 0;
            end
            default: ;
        endcase
        summary = '0;
        summary.released_count = COUNT_W'(freed);
        summary.pending_count  = COUNT_W'(shadow_occ);
        summary.status         = st;
        summary.last           = 1'b1;
    endtask

    // Accept side: run the shadow model on every command transaction,
    // check every result transaction against the oldest owed one
    always @(posedge clk)
    begin
        ftrq_out_t     got;
        ftrq_out_t     want;
        ftrq_out_t     sum;
        summary_hint_t hint;
        string         bad;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cmd_valid && !cmd_stall)
            begin
                moved = 1'b1;
                hint  = '0;
                if (summary_hints.size() != 0)
                    hint = summary_hints.pop_front();
                model_step(cmd_data, sum);
                if (hint.typed)
                    sum = hint.summary;
                owed_results.insert(owed_results.size(), sum);
                accepted_cmds++;
                if (shadow_occ > peak_occ)
                    peak_occ = shadow_occ;
            end
            if (res_valid && !res_stall)
            begin
                moved = 1'b1;
                got   = res_data;
                if (got.is_release)
                    release_results++;
                else
                    summary_results++;
                if (!got.is_release && got.status == STATUS_FULL)
                    full_hits++;
                if (!got.is_release && got.status == STATUS_INVALID)
                    invalid_hits++;
                if (owed_results.size() == 0)
                    flag_fault($sformatf("result transaction with nothing owed: h=%h last=%b",
                                         got.released_handle, got.last));
                else
                begin
                    want = owed_results.pop_front();
                    bad  = "";
                    if (got.released_handle !== want.released_handle)
                        bad = {bad, " released_handle"};
                    if (got.released_kind !== want.released_kind)
                        bad = {bad, " released_kind"};
                    if (got.is_release !== want.is_release)
                        bad = {bad, " is_release"};
                    if (got.released_count !== want.released_count)
                        bad = {bad, " released_count"};
                    if (got.pending_count !== want.pending_count)
                        bad = {bad, " pending_count"};
                    if (got.status !== want.status)
                        bad = {bad, " status"};
                    if (got.last !== want.last)
                        bad = {bad, " last"};
                    if (bad != "")
                        flag_fault($sformatf({"mismatch on%s: exp h=%h k=%b rel=%b rc=%0d ",
                                              "pc=%0d st=%0d last=%b, got h=%h k=%b rel=%b ",
                                              "rc=%0d pc=%0d st=%0d last=%b"},
                                             bad, want.released_handle, want.released_kind,
                                             want.is_release, want.released_count,
                                             want.pending_count, want.status, want.last,
                                             got.released_handle, got.released_kind,
                                             got.is_release, got.released_count,
                                             got.pending_count, got.status, got.last));
                end
            end
            // watchdog on cycles with no transaction on either side
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles, %0d results still owed",
                         WATCHDOG_LIMIT, owed_results.size());
                $display("tb_fence_tagged_release_queue_top: done, errors");
                $finish;
            end
        end
    end

    // Result-side back-pressure in bursts, with quiet stretches
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_quiet = !stall_quiet;
            if (!calm && !stall_quiet && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic ftrq_in_t mk_cmd(input logic [CMD_W-1:0] code,
                                        input logic [HANDLE_W-1:0] h, input logic ok,
                                        input logic desc, input logic [FENCE_W-1:0] f);
        ftrq_in_t c;
        c.cmd           = code;
        c.handle        = h;
        c.handle_valid  = ok;
        c.is_descriptor = desc;
        c.fence         = f;
        return c;
    endfunction

    function automatic ftrq_out_t mk_sum(input int rc, input int pc,
                                         input logic [STATUS_W-1:0] st);
        ftrq_out_t s;
        s = '0;
        s.released_count = COUNT_W'(rc);
        s.pending_count  = COUNT_W'(pc);
        s.status         = st;
        s.last           = 1'b1;
        return s;
    endfunction

    task automatic add_row(input ftrq_in_t c, input logic typed, input ftrq_out_t s);
        cmd_row_t r;
        r.cmd     = c;
        r.typed   = typed;
        r.summary = s;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Mostly small fences so collects hit and miss, plus the extremes
    function automatic logic [FENCE_W-1:0] rand_fence();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return FENCE_W'($urandom_range(0, 15));
        else if (pick == 6)
            return '0;
        else if (pick == 7)
            return FENCE_MAX;
        return {$urandom, $urandom};
    endfunction

    function automatic ftrq_in_t rand_push();
        logic [CMD_W-1:0] code;
        code = ($urandom_range(0, 2) == 0) ? CMD_PUSH_UNSEALED : CMD_PUSH_FENCE;
        return mk_cmd(code, $urandom, 1'b1, 1'($urandom_range(0, 1)), rand_fence());
    endfunction

    // Present one command transaction, possibly after a short gap,
    // and hold it until taken; returns on the following falling edge
    task automatic send_cmd(input ftrq_in_t c, input logic typed, input ftrq_out_t s);
        summary_hint_t hint;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        hint.typed   = typed;
        hint.summary = s;
        summary_hints.insert(summary_hints.size(), hint);
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input ftrq_in_t c);
        send_cmd(c, 1'b0, '0);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (owed_results.size() != 0);
    endtask

    // Stimulus
    initial
    begin
        ftrq_in_t c;
        int       episode;
        bit       mid_pause_done;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd_data       = '0;
        fault_count    = 0;
        idle_cycles    = 0;
        items_sent     = 0;
        accepted_cmds  = 0;
        release_results = 0;
        summary_results = 0;
        full_hits      = 0;
        invalid_hits   = 0;
        peak_occ       = 0;
        shadow_occ     = 0;
        calm           = 1'b0;
        stall_quiet    = 1'b0;
        mid_pause_done = 1'b0;
        episode        = 0;

        // Directed part: empty table, invalid handles, fence extremes,
        // seal of unsealed entries only, stable compaction, spare codes
        add_row(mk_cmd(CMD_COLLECT, '0, 1'b0, 1'b0, FENCE_MAX), 1'b1, mk_sum(0, 0, STATUS_OK));
        add_row(mk_cmd(CMD_SEAL, '1, 1'b1, 1'b1, '0), 1'b1, mk_sum(0, 0, STATUS_OK));
        add_row(mk_cmd(CMD_RELEASE_ALL, '0, 1'b1, 1'b0, '0), 1'b1, mk_sum(0, 0, STATUS_OK));
        add_row(mk_cmd(CMD_PUSH_FENCE, '1, 1'b0, 1'b1, '0), 1'b1,
                mk_sum(0, 0, STATUS_INVALID));
        add_row(mk_cmd(CMD_PUSH_UNSEALED, 32'h1234_5678, 1'b0, 1'b0, FENCE_MAX), 1'b1,
                mk_sum(0, 0, STATUS_INVALID));
        add_row(mk_cmd(CMD_PUSH_FENCE, '1, 1'b1, 1'b1, FENCE_MAX), 1'b1,
                mk_sum(0, 1, STATUS_OK));
        add_row(mk_cmd(CMD_PUSH_UNSEALED, '0, 1'b1, 1'b0, FENCE_MAX), 1'b1,
                mk_sum(0, 2, STATUS_OK));
        add_row(mk_cmd(CMD_PUSH_FENCE, 32'hA5A5_A5A5, 1'b1, 1'b0, '0), 1'b1,
                mk_sum(0, 3, STATUS_OK));
        add_row(mk_cmd(CMD_COLLECT, '1, 1'b1, 1'b1, '0), 1'b0, '0);
        add_row(mk_cmd(CMD_COLLECT, '0, 1'b0, 1'b0, FENCE_MAX - 1), 1'b0, '0);
        add_row(mk_cmd(CMD_SEAL, '0, 1'b0, 1'b0, 64'h8000_0000_0000_0000), 1'b0, '0);
        add_row(mk_cmd(CMD_PUSH_UNSEALED, 32'h5A5A_5A5A, 1'b1, 1'b1, '0), 1'b0, '0);
        add_row(mk_cmd(CMD_COLLECT, '0, 1'b1, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF), 1'b0, '0);
        add_row(mk_cmd(CMD_SPARE_LO, 32'hFFFF_0000, 1'b1, 1'b1, FENCE_MAX), 1'b1,
                mk_sum(0, 3, STATUS_OK));
        add_row(mk_cmd(CMD_SPARE_MID, 32'h0000_FFFF, 1'b0, 1'b0, '0), 1'b1,
                mk_sum(0, 3, STATUS_OK));
        add_row(mk_cmd(CMD_SPARE_HI, '1, 1'b1, 1'b1, FENCE_MAX), 1'b1,
                mk_sum(0, 3, STATUS_OK));
        add_row(mk_cmd(CMD_COLLECT, '0, 1'b0, 1'b0, FENCE_MAX), 1'b0, '0);
        add_row(mk_cmd(CMD_RELEASE_ALL, '1, 1'b0, 1'b1, FENCE_MAX), 1'b0, '0);
        add_row(mk_cmd(CMD_PUSH_FENCE, 32'd1, 1'b1, 1'b0, 64'd5), 1'b0, '0);
        add_row(mk_cmd(CMD_PUSH_UNSEALED, 32'd2, 1'b1, 1'b1, '0), 1'b0, '0);
        add_row(mk_cmd(CMD_PUSH_FENCE, 32'd3, 1'b1, 1'b0, 64'd3), 1'b0, '0);
        add_row(mk_cmd(CMD_SEAL, '0, 1'b0, 1'b0, 64'd4), 1'b0, '0);
        add_row(mk_cmd(CMD_COLLECT, '0, 1'b0, 1'b0, 64'd4), 1'b0, '0);
        add_row(mk_cmd(CMD_RELEASE_ALL, '0, 1'b0, 1'b0, '0), 1'b0, '0);

        // Reset
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].summary);
        drain();

        // Random part in episodes: fill to full, realistic push/seal/collect
        // rounds, and odd noise
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET * 4 / 5)
                calm = 1'b1;
            if (!mid_pause_done && items_sent >= ITEM_TARGET / 2)
            begin
                drain();
                mid_pause_done = 1'b1;
            end
            if (episode == 0 || episode == 6 || $urandom_range(0, 11) == 0)
            begin
                // fill the table, then overflow it
                while (shadow_occ < QUEUE_DEPTH && items_sent < ITEM_TARGET)
                    send_random(rand_push());
                repeat (2)
                begin
                    c = rand_push();
                    c.handle_valid = 1'($urandom_range(0, 1));
                    send_random(c);
                end
                c = mk_cmd(($urandom_range(0, 1) != 0) ? CMD_RELEASE_ALL : CMD_COLLECT,
                           $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           rand_fence());
                send_random(c);
            end
            else if ($urandom_range(0, 4) != 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    c = rand_push();
                    if ($urandom_range(0, 9) == 0)
                        c.handle_valid = 1'b0;
                    send_random(c);
                end
                if ($urandom_range(0, 1) != 0)
                    send_random(mk_cmd(CMD_SEAL, $urandom, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), rand_fence()));
                send_random(mk_cmd(CMD_COLLECT, $urandom, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), rand_fence()));
                if ($urandom_range(0, 5) == 0)
                    send_random(mk_cmd(CMD_RELEASE_ALL, $urandom, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), rand_fence()));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_random(mk_cmd(CMD_W'($urandom_range(0, 7)), $urandom,
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       {$urandom, $urandom}));
            end
            episode++;
        end

        // Wind down: wait for the owed results, then let the block settle
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (owed_results.size() != 0)
            flag_fault($sformatf("%0d results never arrived", owed_results.size()));

        $display("covered %0d commands, %0d releases and %0d summaries returned",
                 accepted_cmds, release_results, summary_results);
        $display("table full drops %0d, invalid-handle drops %0d, peak occupancy %0d",
                 full_hits, invalid_hits, peak_occ);
        if (fault_count == 0)
            $display("tb_fence_tagged_release_queue_top: done, clean");
        else
            $display("tb_fence_tagged_release_queue_top: done, errors");
        $finish;
    end

endmodule
